/* rtl/ptrs_pkg.sv */
package ptrs_pkg;

   localparam int NumTasks      = 3;
   localparam int TaskIdxWidth  = 2;
   localparam int DlAddrWidth   = (NumTasks > 1) ? $clog2(NumTasks) : 1;
   localparam int TimeWidth     = 64;
   localparam int CycleWidth    = 63;
   localparam int CsrIndexWidth = 3;
   localparam int KindWidth     = 3;
   localparam int ReqTypeWidth  = 2;
   localparam int CountWidth    = 2;

   localparam logic [ReqTypeWidth-1:0] REQ_ARM  = 2'd0;
   localparam logic [ReqTypeWidth-1:0] REQ_POLL = 2'd1;
   localparam logic [ReqTypeWidth-1:0] REQ_DONE = 2'd2;

   localparam logic [KindWidth-1:0] RSP_ARMED    = 3'd0;
   localparam logic [KindWidth-1:0] RSP_DISPATCH = 3'd1;
   localparam logic [KindWidth-1:0] RSP_WAKE     = 3'd2;
   localparam logic [KindWidth-1:0] RSP_OK       = 3'd3;
   localparam logic [KindWidth-1:0] RSP_OVERRUN  = 3'd4;

   localparam logic [CsrIndexWidth-1:0] CSR_TASKS_IN_USE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PERIOD_TASK0 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BUDGET_TASK0 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PERIOD_TASK1 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_BUDGET_TASK1 = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_PERIOD_TASK2 = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_BUDGET_TASK2 = 3'd6;

   localparam logic [CountWidth-1:0] RST_TASKS_IN_USE = 2'd2;
   localparam logic [CycleWidth-1:0] RST_PERIOD_TASK0 = 63'd1000000;
   localparam logic [CycleWidth-1:0] RST_BUDGET_TASK0 = 63'd300000;
   localparam logic [CycleWidth-1:0] RST_PERIOD_TASK1 = 63'd10000000;
   localparam logic [CycleWidth-1:0] RST_BUDGET_TASK1 = 63'd1000000;
   localparam logic [CycleWidth-1:0] RST_PERIOD_TASK2 = 63'd10000000;
   localparam logic [CycleWidth-1:0] RST_BUDGET_TASK2 = 63'd1000000;

   typedef struct packed {
      logic [CountWidth-1:0]                    tasks_in_use;
      logic [NumTasks-1:0][CycleWidth-1:0]      period;
      logic [NumTasks-1:0][CycleWidth-1:0]      budget;
   } cfg_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ARM  = 6'b000010,
      ST_RD   = 6'b000100,
      ST_CHK  = 6'b001000,
      ST_DISP = 6'b010000,
      ST_LAST = 6'b100000
   } state_type;

endpackage

/* rtl/ptrs_ram.sv */
module ptrs_ram #(
   parameter int Width = 64,
   parameter int Depth = 3
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(Depth)-1:0]         wr_addr,
   input  logic [Width-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(Depth)-1:0]         rd_addr,
   output logic [Width-1:0]                 rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ptrs_core.sv */
module ptrs_core
   import ptrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ReqTypeWidth-1:0]   req_type,
   input  logic [TimeWidth-1:0]      req_now_time,
   input  logic [TaskIdxWidth-1:0]   req_task_id,
   input  logic [TimeWidth-1:0]      req_elapsed_cycles,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [KindWidth-1:0]      rsp_result_kind,
   output logic [TaskIdxWidth-1:0]   rsp_task_index,
   output logic [TimeWidth-1:0]      rsp_wake_time,
   output logic                      rsp_last_of_run
);

   state_type                  state_ff, state_in;
   logic [TaskIdxWidth-1:0]    idx_ff, idx_in;
   logic [TimeWidth-1:0]       now_ff, now_in;
   logic [TimeWidth-1:0]       best_ff, best_in;
   logic [KindWidth-1:0]       pend_kind_ff, pend_kind_in;
   logic [TaskIdxWidth-1:0]    pend_idx_ff, pend_idx_in;
   logic [NumTasks-1:0]        valid_ff, valid_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [KindWidth-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [TaskIdxWidth-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [TimeWidth-1:0]       rsp_wake_ff, rsp_wake_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       wr_en;
   logic [TimeWidth-1:0]       wr_data;
   logic                       rd_en;
   logic [TimeWidth-1:0]       rd_data;
   logic [DlAddrWidth-1:0]     dl_addr;

   logic                       out_free;
   logic [TaskIdxWidth-1:0]    last_idx;
   logic [TimeWidth-1:0]       deadline;
   logic [TimeWidth-1:0]       lag;
   logic [TimeWidth-1:0]       advanced;
   logic [TimeWidth-1:0]       updated;
   logic                       due;
   logic [TimeWidth-1:0]       period_ext;

   assign dl_addr  = idx_ff[DlAddrWidth-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   ptrs_ram #(
      .Width(TimeWidth),
      .Depth(NumTasks)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (dl_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (dl_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (cfg.tasks_in_use == '0) begin
         last_idx = '0;
      end else if (cfg.tasks_in_use > TaskIdxWidth'(NumTasks)) begin
         last_idx = TaskIdxWidth'(NumTasks - 1);
      end else begin
         last_idx = cfg.tasks_in_use - 1'b1;
      end
   end

   assign period_ext = {1'b0, cfg.period[dl_addr]};
   assign deadline   = valid_ff[dl_addr] ? rd_data : '0;
   assign lag        = now_ff - deadline;
   assign due        = !lag[TimeWidth-1];
   assign advanced   = deadline + period_ext;
   assign updated    = due ? advanced : deadline;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      best_in      = best_ff;
      pend_kind_in = pend_kind_ff;
      pend_idx_in  = pend_idx_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_wake_in  = rsp_wake_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_data      = now_ff + period_ext;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_now_time;
               idx_in = '0;
               unique case (req_type)
                  REQ_ARM: begin
                     state_in = ST_ARM;
                  end
                  REQ_POLL: begin
                     state_in = ST_RD;
                  end
                  REQ_DONE: begin
                     if (req_task_id < TaskIdxWidth'(NumTasks)) begin
                        pend_idx_in  = req_task_id;
                        pend_kind_in = (req_elapsed_cycles >
                                        {1'b0, cfg.budget[req_task_id[DlAddrWidth-1:0]]})
                                       ? RSP_OVERRUN : RSP_OK;
                        state_in     = ST_LAST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ARM: begin
            wr_en            = 1'b1;
            valid_in[dl_addr] = 1'b1;
            if (idx_ff == TaskIdxWidth'(NumTasks - 1)) begin
               pend_kind_in = RSP_ARMED;
               pend_idx_in  = '0;
               state_in     = ST_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (due) begin
               wr_en             = 1'b1;
               wr_data           = advanced;
               valid_in[dl_addr] = 1'b1;
            end
            if (idx_ff == '0 || updated < best_ff) begin
               best_in = updated;
            end
            if (due) begin
               state_in = ST_DISP;
            end else if (idx_ff == last_idx) begin
               pend_kind_in = RSP_WAKE;
               pend_idx_in  = '0;
               state_in     = ST_LAST;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_DISP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RSP_DISPATCH;
               rsp_idx_in   = idx_ff;
               rsp_wake_in  = '0;
               rsp_last_in  = 1'b0;
               if (idx_ff == last_idx) begin
                  pend_kind_in = RSP_WAKE;
                  pend_idx_in  = '0;
                  state_in     = ST_LAST;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_idx_in   = pend_idx_ff;
               rsp_wake_in  = (pend_kind_ff == RSP_WAKE) ? best_ff : '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      now_ff       <= now_in;
      best_ff      <= best_in;
      pend_kind_ff <= pend_kind_in;
      pend_idx_ff  <= pend_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_wake_ff  <= rsp_wake_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_task_index  = rsp_idx_ff;
   assign rsp_wake_time   = rsp_wake_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

/* rtl/periodic_task_release_scheduler_unit.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_type, req_now_time, req_task_id,
//                                           req_elapsed_cycles
// rsp       out        rsp_valid/rsp_ready  rsp_result_kind, rsp_task_index,
//                                           rsp_wake_time, rsp_last_of_run
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// One request is in flight at a time; req_ready is high only while the unit is idle.
// An arm does one deadline memory write per task and then issues its result, and a
// completion issues its result directly. A poll reads each active task's deadline, then
// checks and writes it back, dispatches each due task and ends with the wake result;
// rsp stalls hold the scan.
// Synchronous reset clears the deadlines to zero through per-entry valid bits.
module periodic_task_release_scheduler_unit
   import ptrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ReqTypeWidth-1:0]   req_type,
   input  logic [TimeWidth-1:0]      req_now_time,
   input  logic [TaskIdxWidth-1:0]   req_task_id,
   input  logic [TimeWidth-1:0]      req_elapsed_cycles,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [KindWidth-1:0]      rsp_result_kind,
   output logic [TaskIdxWidth-1:0]   rsp_task_index,
   output logic [TimeWidth-1:0]      rsp_wake_time,
   output logic                      rsp_last_of_run,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [TimeWidth-1:0]      csr_data
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TASKS_IN_USE: cfg_in.tasks_in_use = csr_data[CountWidth-1:0];
            CSR_PERIOD_TASK0: cfg_in.period[0]    = csr_data[CycleWidth-1:0];
            CSR_BUDGET_TASK0: cfg_in.budget[0]    = csr_data[CycleWidth-1:0];
            CSR_PERIOD_TASK1: cfg_in.period[1]    = csr_data[CycleWidth-1:0];
            CSR_BUDGET_TASK1: cfg_in.budget[1]    = csr_data[CycleWidth-1:0];
            CSR_PERIOD_TASK2: cfg_in.period[2]    = csr_data[CycleWidth-1:0];
            CSR_BUDGET_TASK2: cfg_in.budget[2]    = csr_data[CycleWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tasks_in_use <= RST_TASKS_IN_USE;
         cfg_ff.period[0]    <= RST_PERIOD_TASK0;
         cfg_ff.budget[0]    <= RST_BUDGET_TASK0;
         cfg_ff.period[1]    <= RST_PERIOD_TASK1;
         cfg_ff.budget[1]    <= RST_BUDGET_TASK1;
         cfg_ff.period[2]    <= RST_PERIOD_TASK2;
         cfg_ff.budget[2]    <= RST_BUDGET_TASK2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptrs_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_now_time       (req_now_time),
      .req_task_id        (req_task_id),
      .req_elapsed_cycles (req_elapsed_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_task_index     (rsp_task_index),
      .rsp_wake_time      (rsp_wake_time),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

/* rtl/ptrs_checker.sv */
module ptrs_checker
   import ptrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [KindWidth-1:0]      rsp_result_kind,
   input  logic [TaskIdxWidth-1:0]   rsp_task_index,
   input  logic [TimeWidth-1:0]      rsp_wake_time,
   input  logic                      rsp_last_of_run
);

   // A stalled result transfer keeps its kind, task index and wake time.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_task_index) && $stable(rsp_wake_time))
      else $error("rsp payload changed while stalled");

   // Only dispatch results leave the run open.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_run == (rsp_result_kind != RSP_DISPATCH)))
      else $error("last_of_run does not match result kind");

   a_wake_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != RSP_WAKE |-> rsp_wake_time == '0)
      else $error("wake time set on a non-wake result");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RSP_ARMED || rsp_result_kind == RSP_WAKE)
         |-> rsp_task_index == '0)
      else $error("task index set on an armed or wake result");

   // While a run is still open, no new request transfer is taken.
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready || !req_valid)
      else $error("request accepted in the middle of a poll");

endmodule

bind periodic_task_release_scheduler_unit ptrs_checker u_ptrs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_task_index  (rsp_task_index),
   .rsp_wake_time   (rsp_wake_time),
   .rsp_last_of_run (rsp_last_of_run)
);
